/* sv/assert_macros.svh */
// assertion macros shared by the alpha blend rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/abob_pkg.sv */
// shared types and constants for the argb over blend pipeline
// no dependencies
package abob_pkg;

	localparam int CH_W  = 8;   // bits per channel
	localparam int CH_N  = 3;   // color channels: 0 red, 1 green, 2 blue
	localparam int DEN_W = 16;  // denominator, at most 255*255
	localparam int NUM_W = 24;  // numerator, below 256 * denominator
	localparam int QUO_W = 8;   // quotient bits, one divider cell each

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} argb_t;

	// payload handed from cell to cell
	typedef struct packed {
		logic                        bypass;
		logic [CH_W-1:0]             alpha;
		logic [DEN_W-1:0]            den;
		logic [CH_N-1:0][NUM_W-1:0]  rem;
		logic [CH_N-1:0][CH_W-1:0]   quo;
	} cell_data_t;

endpackage

/* sv/abob_prep.sv */
// front end of the blend pipeline: weights, products and sums in three stages
// depends on abob_pkg and assert_macros.svh
`include "assert_macros.svh"
module abob_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  abob_pkg::argb_t      back_px,
	input  abob_pkg::argb_t      front_px,
	output logic                 cell_valid,
	input  logic                 cell_ready,
	output abob_pkg::cell_data_t cell_data
);
	import abob_pkg::*;

	logic ready_s1, ready_s2, ready_s3;
	logic valid_s1, valid_s2, valid_s3;

	// stage 1 registers
	logic                       byp_s1;
	argb_t                      bpx_s1;
	logic [DEN_W-1:0]           fa255_s1;
	logic [DEN_W-1:0]           w_s1;
	logic [CH_N-1:0][CH_W-1:0]  fc_s1;
	logic [CH_N-1:0][CH_W-1:0]  bc_s1;

	// stage 2 registers
	logic                       byp_s2;
	argb_t                      bpx_s2;
	logic [DEN_W-1:0]           den_s2;
	logic [CH_N-1:0][NUM_W-1:0] pf_s2;
	logic [CH_N-1:0][NUM_W-1:0] pb_s2;

	// stage 3 register
	cell_data_t                 data_s3;

	logic                       byp_c;
	argb_t                      bpx_c;
	logic [DEN_W:0]             alpha_sum;
	cell_data_t                 data_c;

	// ready ripples back through empty stages
	assign ready_s3  = !valid_s3 || cell_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= pix_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// special cases: clear front shows back, clear back or opaque front shows front
	always_comb begin
		byp_c = (front_px.a == '0) || (back_px.a == '0) || (front_px.a == CH_MAX);
		bpx_c = (front_px.a == '0) ? back_px : front_px;
	end

	// stage 1: front weight and back weight
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			byp_s1   <= byp_c;
			bpx_s1   <= bpx_c;
			fa255_s1 <= DEN_W'(front_px.a) * DEN_W'(CH_MAX);
			w_s1     <= DEN_W'(back_px.a) * DEN_W'(CH_MAX - front_px.a);
			fc_s1    <= {front_px.b, front_px.g, front_px.r};
			bc_s1    <= {back_px.b, back_px.g, back_px.r};
		end
	end

	// stage 2: per-channel products and the denominator
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			byp_s2 <= byp_s1;
			bpx_s2 <= bpx_s1;
			den_s2 <= fa255_s1 + w_s1;
			for (int ch = 0; ch < CH_N; ch++) begin
				pf_s2[ch] <= NUM_W'(fc_s1[ch]) * NUM_W'(fa255_s1);
				pb_s2[ch] <= NUM_W'(bc_s1[ch]) * NUM_W'(w_s1);
			end
		end
	end

	// stage 3 comb: numerators, alpha as den/255, bypass pixel preloaded
	always_comb begin
		alpha_sum = {1'b0, den_s2} + (DEN_W+1)'(1) + (DEN_W+1)'(den_s2 >> CH_W);
		data_c.bypass = byp_s2;
		data_c.den    = den_s2;
		data_c.alpha  = byp_s2 ? bpx_s2.a : alpha_sum[2*CH_W-1:CH_W];
		for (int ch = 0; ch < CH_N; ch++) begin
			data_c.rem[ch] = pf_s2[ch] + pb_s2[ch];
		end
		data_c.quo = byp_s2 ? {bpx_s2.b, bpx_s2.g, bpx_s2.r} : '0;
	end

	always_ff @(posedge clk) begin
		if (ready_s3) data_s3 <= data_c;
	end

	assign cell_valid = valid_s3;
	assign cell_data  = data_s3;

	`ASSERT_IMPL(a_den_nonzero, valid_s3 && !data_s3.bypass, data_s3.den != '0,
		"blend stage holds a zero denominator")
	`ASSERT_NEXT(a_s1_held, valid_s1 && !ready_s2, valid_s1,
		"stage 1 beat dropped while downstream stalled")

endmodule

/* sv/abob_div_cell.sv */
// one restoring-division cell: settles quotient bit SHIFT of every channel
// depends on abob_pkg and assert_macros.svh
`include "assert_macros.svh"
module abob_div_cell #(
	parameter int SHIFT = abob_pkg::QUO_W - 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  abob_pkg::cell_data_t up_data,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output abob_pkg::cell_data_t dn_data
);
	import abob_pkg::*;

	logic       valid_q;
	cell_data_t data_q;
	cell_data_t next_c;
	logic [NUM_W-1:0] dsh;

	assign up_ready = !valid_q || dn_ready;

	// trial subtract of the shifted divisor, skipped for bypass beats
	always_comb begin
		next_c = up_data;
		dsh    = NUM_W'(up_data.den) << SHIFT;
		for (int ch = 0; ch < CH_N; ch++) begin
			if (!up_data.bypass && (up_data.rem[ch] >= dsh)) begin
				next_c.rem[ch]        = up_data.rem[ch] - dsh;
				next_c.quo[ch][SHIFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) data_q <= next_c;
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	`ASSERT_IMPL(a_rem_below_div, valid_q && !data_q.bypass,
		(data_q.rem[0] < (NUM_W'(data_q.den) << SHIFT)) &&
		(data_q.rem[1] < (NUM_W'(data_q.den) << SHIFT)) &&
		(data_q.rem[2] < (NUM_W'(data_q.den) << SHIFT)),
		"partial remainder not below shifted divisor")
	`ASSERT_NEXT(a_cell_held, valid_q && !dn_ready, valid_q && $stable(data_q),
		"divider cell beat changed while stalled")

endmodule

/* sv/argb_alpha_over_blend.sv */
// argb_alpha_over_blend: porter-duff over of two straight-alpha argb8888 pixels
//
// input channel pix_valid / pix_ready carries one beat of a back and a front
// pixel; output channel res_valid / res_ready carries one composited pixel.
// a beat is taken at a clock edge with valid and ready both high.
//
// the path runs through three front-end stages (weights, products, sums) and
// a chain of eight divider cells, each settling one quotient bit of red,
// green and blue with one 24-bit trial subtract. the last cell is the output
// register. throughput is one pixel per cycle while res_ready stays high: each
// stage loads whenever it is empty or its successor moves, so bubbles close
// up under back-pressure. while res_ready is low the result holds steady;
// pix_ready drops only once every stage holds a beat.
//
// reset (arst_n low) empties every stage; nothing else needs clearing.
// depends on abob_pkg, abob_prep and abob_div_cell
module argb_alpha_over_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  logic [abob_pkg::CH_W-1:0]  back_alpha,
	input  logic [abob_pkg::CH_W-1:0]  back_red,
	input  logic [abob_pkg::CH_W-1:0]  back_green,
	input  logic [abob_pkg::CH_W-1:0]  back_blue,
	input  logic [abob_pkg::CH_W-1:0]  front_alpha,
	input  logic [abob_pkg::CH_W-1:0]  front_red,
	input  logic [abob_pkg::CH_W-1:0]  front_green,
	input  logic [abob_pkg::CH_W-1:0]  front_blue,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [abob_pkg::CH_W-1:0]  out_alpha,
	output logic [abob_pkg::CH_W-1:0]  out_red,
	output logic [abob_pkg::CH_W-1:0]  out_green,
	output logic [abob_pkg::CH_W-1:0]  out_blue
);
	import abob_pkg::*;

	argb_t      back_px, front_px;
	logic       link_valid [QUO_W+1];
	logic       link_ready [QUO_W+1];
	cell_data_t link_data  [QUO_W+1];

	assign back_px  = '{a: back_alpha,  r: back_red,  g: back_green,  b: back_blue};
	assign front_px = '{a: front_alpha, r: front_red, g: front_green, b: front_blue};

	abob_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.back_px    (back_px),
		.front_px   (front_px),
		.cell_valid (link_valid[0]),
		.cell_ready (link_ready[0]),
		.cell_data  (link_data[0])
	);

	// divider chain, most significant quotient bit first
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		abob_div_cell #(
			.SHIFT (QUO_W - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up_data  (link_data[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn_data  (link_data[i+1])
		);
	end

	// result beat straight from the last cell
	assign res_valid         = link_valid[QUO_W];
	assign link_ready[QUO_W] = res_ready;
	assign out_alpha         = link_data[QUO_W].alpha;
	assign out_red           = link_data[QUO_W].quo[0];
	assign out_green         = link_data[QUO_W].quo[1];
	assign out_blue          = link_data[QUO_W].quo[2];

endmodule
